### design/bounded_lifo_stack_core_assert.svh
// assertion macros for the lifo stack core
// included by the modules that check their own sequencing, no other dependencies
`ifndef BOUNDED_LIFO_STACK_CORE_ASSERT_SVH
`define BOUNDED_LIFO_STACK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define BLSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define BLSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BLSC_ASSERT(lbl, clk, rstn, prop, msg)
`define BLSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### design/blsc_pkg.sv
// shared types and constants for the lifo stack core
// no dependencies
`timescale 1ns / 1ps

package blsc_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int WORD_W        = 32;
    localparam int ACTION_W      = 3;
    localparam int POS_W         = 7;
    localparam int LEVEL_W       = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_TOP   = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_FIND  = 3'd4
    } action_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FIND,
        ST_EMIT
    } state_e;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [WORD_W-1:0] value;
    } s_item_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] data;
        logic [POS_W-1:0]         position;
        logic [LEVEL_W-1:0]       fill_level;
        logic                     is_empty;
    } m_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

### design/blsc_mem.sv
// stack storage: one write port, one registered read port
// depends on blsc_pkg
`timescale 1ns / 1ps

module blsc_mem
    import blsc_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  mem_ctl_t                 ctl,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [WORD_W-1:0] rd_data
);

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/blsc_ctrl.sv
// sequencer, fill count and shared match compare for the lifo stack core
// depends on blsc_pkg and bounded_lifo_stack_core_assert.svh
`timescale 1ns / 1ps

`include "bounded_lifo_stack_core_assert.svh"

module blsc_ctrl
    import blsc_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  s_item_t                  s_item,
    output logic                     emit_valid,
    input  logic                     out_free,
    output m_item_t                  res,
    output mem_ctl_t                 mem_ctl,
    output logic [ADDR_W-1:0]        waddr,
    output logic signed [WORD_W-1:0] wdata,
    output logic [ADDR_W-1:0]        raddr,
    input  logic signed [WORD_W-1:0] rd_data
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    state_e                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic signed [WORD_W-1:0] value_reg, value_next;
    m_item_t                  res_reg, res_next;

    logic                     full;
    logic                     empty;
    logic                     match;
    logic                     take;
    logic [CNT_W-1:0]         fill_dec;
    logic [ADDR_W-1:0]        fill_m1;
    logic [ADDR_W-1:0]        addr_dec;

    function automatic logic [LEVEL_W-1:0] to_level(input logic [CNT_W-1:0] f);
        logic [CNT_W+LEVEL_W-1:0] w;
        w = {{LEVEL_W{1'b0}}, f};
        return w[LEVEL_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] to_pos(input logic [ADDR_W-1:0] a);
        logic [ADDR_W+POS_W-1:0] w;
        w = {{POS_W{1'b0}}, a};
        return w[POS_W-1:0];
    endfunction

    assign full     = (fill_reg == FULL);
    assign empty    = (fill_reg == '0);
    assign take     = s_valid && s_ready;
    assign fill_dec = fill_reg - 1'b1;
    assign fill_m1  = fill_dec[ADDR_W-1:0];
    assign addr_dec = addr_reg - 1'b1;
    // the one comparator, reused for every entry of a search
    assign match    = (rd_data == value_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (!empty && (s_item.action inside {ACT_POP, ACT_TOP})) begin
                        state_next = ST_READ;
                    end else if (!empty && s_item.action == ACT_FIND) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_FIND: begin
                if (match || addr_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        fill_next     = fill_reg;
        addr_next     = addr_reg;
        value_next    = value_reg;
        res_next      = res_reg;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        raddr         = fill_m1;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    value_next = s_item.value;
                    addr_next  = fill_m1;
                    res_next   = '0;
                    case (s_item.action)
                        ACT_PUSH: begin
                            if (!full) begin
                                mem_ctl.wr_en = 1'b1;
                                fill_next     = fill_reg + 1'b1;
                                res_next.ok   = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (!empty) begin
                                mem_ctl.rd_en = 1'b1;
                                fill_next     = fill_dec;
                            end
                        end
                        ACT_TOP, ACT_FIND: begin
                            if (!empty) begin
                                mem_ctl.rd_en = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            fill_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    res_next.fill_level = to_level(fill_next);
                    res_next.is_empty   = (fill_next == '0);
                end
            end
            ST_READ: begin
                res_next.ok   = 1'b1;
                res_next.data = rd_data;
            end
            ST_FIND: begin
                if (match) begin
                    res_next.ok       = 1'b1;
                    res_next.data     = value_reg;
                    res_next.position = to_pos(addr_reg);
                end else if (addr_reg != '0) begin
                    mem_ctl.rd_en = 1'b1;
                    raddr         = addr_dec;
                    addr_next     = addr_dec;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign emit_valid = (state_reg == ST_EMIT);
    assign res        = res_reg;
    assign waddr      = fill_reg[ADDR_W-1:0];
    assign wdata      = s_item.value;

    `BLSC_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FULL, "fill count above depth")
    `BLSC_ASSERT(a_scan_in_range, aclk, aresetn, state_reg != ST_FIND || addr_reg < fill_reg, "search slot not below fill count")
    `BLSC_ASSERT_NEXT(a_push_grows, aclk, aresetn, take && s_item.action == ACT_PUSH && !full, fill_reg == $past(fill_reg) + 1'b1, "accepted push did not grow the stack")
    `BLSC_ASSERT_NEXT(a_emit_holds, aclk, aresetn, emit_valid && !out_free, emit_valid && $stable(res_reg), "pending result lost while output busy")

endmodule

### design/bounded_lifo_stack_core.sv
// top level of the lifo stack core: sequencer, storage and output register
// depends on blsc_pkg, blsc_mem and blsc_ctrl
`timescale 1ns / 1ps

// Bounded LIFO stack of DEPTH signed 32-bit words. Each input word carries an action
// (push, pop, top, clear, find) and a value, and gives exactly one result word with
// ok, data, position, fill level and empty flag. Words are taken one at a time: s_ready
// is high only while the sequencer is idle. Push, clear and unknown actions go from idle
// straight to the emit state; pop and top on a nonempty stack pass through a read state,
// since the storage read port is registered, and go straight to emit on an empty one;
// find compares entries from the top down, one entry per cycle through the one shared
// comparator, until a match or the bottom entry (none on an empty stack, so at most the
// fill level). A finished result waits in emit while the output register is still
// held by an earlier word. A result sits in the output register until m_ready takes it,
// and the next input word is accepted meanwhile.
// Clear only resets the fill count, so there is no clearing pass after reset.

module bounded_lifo_stack_core
    import blsc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  s_item_t s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_item
);

    localparam int ADDR_W = $clog2(DEPTH);

    // sequencer to storage
    mem_ctl_t                 mem_ctl;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        raddr;
    logic signed [WORD_W-1:0] wdata;
    logic signed [WORD_W-1:0] rd_data;

    // result handoff into the output register
    logic    emit_valid;
    logic    out_free;
    m_item_t res;

    logic    m_valid_reg, m_valid_next;
    m_item_t m_item_reg;

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    blsc_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .emit_valid (emit_valid),
        .out_free   (out_free),
        .res        (res),
        .mem_ctl    (mem_ctl),
        .waddr      (waddr),
        .wdata      (wdata),
        .raddr      (raddr),
        .rd_data    (rd_data)
    );

    blsc_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rd_data (rd_data)
    );

    // valid flag: set on handoff, cleared once the word is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_valid && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only on handoff so it holds while stalled
    always_ff @(posedge aclk) begin
        if (emit_valid && out_free) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
